// ===== src/sst_pkg.sv =====
// sst_pkg: types, constants and line-parsing functions for the sse stream tokenizer
// used by sst_front, sst_queue, sst_back and sse_stream_tokenizer; no dependencies
package sst_pkg;

  localparam logic [7:0] LF_BYTE    = 8'd10;
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] COLON_BYTE = 8'd58;
  localparam logic [7:0] SPACE_BYTE = 8'd32;

  typedef enum logic [2:0] {
    KIND_DATA        = 3'd0,
    KIND_EVENT_START = 3'd1,
    KIND_EVENT_BYTE  = 3'd2,
    KIND_ID_START    = 3'd3,
    KIND_ID_BYTE     = 3'd4,
    KIND_DISPATCH    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_NAME        = 3'd1,
    PH_SKIP        = 3'd2,
    PH_AFTER_COLON = 3'd3,
    PH_VALUE       = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    FIELD_NONE  = 2'd0,
    FIELD_DATA  = 2'd1,
    FIELD_EVENT = 2'd2,
    FIELD_ID    = 2'd3
  } field_e;

  typedef struct packed {
    phase_e     phase;
    field_e     sel;
    logic [2:0] pos;
    logic       dls;
  } line_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    line_t st;
    logic  tv;
    tok_t  tok;
  } step_t;

  // tokens caused by one input byte, in order
  typedef struct packed {
    tok_t t0;
    tok_t t1;
    logic two;
  } run_t;

  localparam line_t LINE_RESET = '{phase: PH_START, sel: FIELD_NONE, pos: 3'd0, dls: 1'b0};
  localparam tok_t  TOK_NONE   = '{kind: KIND_DATA, data: 8'd0};

  function automatic logic [2:0] field_len(field_e f);
    logic [2:0] len;
    case (f)
      FIELD_DATA:  len = 3'd4;
      FIELD_EVENT: len = 3'd5;
      FIELD_ID:    len = 3'd2;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] name_char(field_e f, logic [2:0] p);
    logic [7:0] ch;
    ch = 8'd0;
    case (f)
      FIELD_DATA: begin
        case (p)
          3'd0:    ch = "d";
          3'd1:    ch = "a";
          3'd2:    ch = "t";
          3'd3:    ch = "a";
          default: ch = 8'd0;
        endcase
      end
      FIELD_EVENT: begin
        case (p)
          3'd0:    ch = "e";
          3'd1:    ch = "v";
          3'd2:    ch = "e";
          3'd3:    ch = "n";
          3'd4:    ch = "t";
          default: ch = 8'd0;
        endcase
      end
      FIELD_ID: begin
        case (p)
          3'd0:    ch = "i";
          3'd1:    ch = "d";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic kind_e value_kind(field_e f);
    kind_e k;
    case (f)
      FIELD_EVENT: k = KIND_EVENT_BYTE;
      FIELD_ID:    k = KIND_ID_BYTE;
      default:     k = KIND_DATA;
    endcase
    return k;
  endfunction

  // one non-LF byte applied to the line state
  function automatic step_t take_byte(line_t s, logic [7:0] c);
    step_t      r;
    logic [2:0] len;
    r.st  = s;
    r.tv  = 1'b0;
    r.tok = TOK_NONE;
    len   = field_len(s.sel);
    case (s.phase)
      PH_START: begin
        r.st.pos = 3'd0;
        if (c == "d") begin
          r.st.sel = FIELD_DATA;
        end else if (c == "e") begin
          r.st.sel = FIELD_EVENT;
        end else if (c == "i") begin
          r.st.sel = FIELD_ID;
        end else begin
          r.st.sel = FIELD_NONE;
        end
        if (r.st.sel != FIELD_NONE) begin
          r.st.phase = PH_NAME;
          r.st.pos   = 3'd1;
        end else begin
          r.st.phase = PH_SKIP;
        end
      end
      PH_NAME: begin
        if ((s.pos < len) && (c == name_char(s.sel, s.pos))) begin
          r.st.pos = s.pos + 3'd1;
        end else if ((c == COLON_BYTE) && (s.pos == len) && (s.sel != FIELD_NONE)) begin
          if (s.sel == FIELD_DATA) begin
            if (s.dls) begin
              r.tv  = 1'b1;
              r.tok = '{kind: KIND_DATA, data: LF_BYTE};
            end
            r.st.dls = 1'b1;
          end else if (s.sel == FIELD_EVENT) begin
            r.tv  = 1'b1;
            r.tok = '{kind: KIND_EVENT_START, data: 8'd0};
          end else begin
            r.tv  = 1'b1;
            r.tok = '{kind: KIND_ID_START, data: 8'd0};
          end
          r.st.phase = PH_AFTER_COLON;
        end else begin
          r.st.phase = PH_SKIP;
        end
      end
      PH_AFTER_COLON: begin
        r.st.phase = PH_VALUE;
        if (c != SPACE_BYTE) begin
          r.tv  = 1'b1;
          r.tok = '{kind: value_kind(s.sel), data: c};
        end
      end
      PH_VALUE: begin
        r.tv  = 1'b1;
        r.tok = '{kind: value_kind(s.sel), data: c};
      end
      default: begin
        r.tv = 1'b0;
      end
    endcase
    return r;
  endfunction

  // LF: dispatch on an empty line after data, then back to line start
  function automatic step_t end_line(line_t s);
    step_t r;
    r.st  = s;
    r.tv  = 1'b0;
    r.tok = TOK_NONE;
    if ((s.phase == PH_START) && s.dls) begin
      r.tv     = 1'b1;
      r.tok    = '{kind: KIND_DISPATCH, data: 8'd0};
      r.st.dls = 1'b0;
    end
    r.st.phase = PH_START;
    r.st.sel   = FIELD_NONE;
    r.st.pos   = 3'd0;
    return r;
  endfunction

endpackage

// ===== src/sst_front.sv =====
// sst_front: accepts stream bytes, keeps the line state and forms the token run of each byte
// depends on sst_pkg; feeds sst_queue
module sst_front import sst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       full_i,
  output logic       push_o,
  output run_t       run_o
);

  line_t line_q, line_d;
  logic  cr_q, cr_d;
  logic  fire;
  logic  is_lf, is_cr;
  step_t s_cr, s_byte, s_end;
  line_t st_mid;
  logic  a_v, b_v;
  tok_t  a_tok, b_tok;

  assign in_stall_o = full_i;
  assign fire       = in_valid_i && !full_i;
  assign is_lf      = (byte_in_i == LF_BYTE);
  assign is_cr      = (byte_in_i == CR_BYTE);

  // next line state
  always_comb begin
    s_cr   = take_byte(line_q, CR_BYTE);
    st_mid = cr_q ? s_cr.st : line_q;
    s_byte = take_byte(st_mid, byte_in_i);
    s_end  = end_line(line_q);
    if (is_lf) begin
      line_d = s_end.st;
      cr_d   = 1'b0;
    end else begin
      line_d = is_cr ? st_mid : s_byte.st;
      cr_d   = is_cr;
    end
  end

  // token run of this item
  always_comb begin
    a_v   = cr_q && !is_lf && s_cr.tv;
    a_tok = s_cr.tok;
    if (is_lf) begin
      b_v   = s_end.tv;
      b_tok = s_end.tok;
    end else begin
      b_v   = !is_cr && s_byte.tv;
      b_tok = s_byte.tok;
    end
    if (a_v) begin
      run_o.t0  = a_tok;
      run_o.t1  = b_tok;
      run_o.two = b_v;
    end else begin
      run_o.t0  = b_tok;
      run_o.t1  = TOK_NONE;
      run_o.two = 1'b0;
    end
    push_o = fire && (a_v || b_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LINE_RESET;
      cr_q   <= 1'b0;
    end else if (fire) begin
      line_q <= line_d;
      cr_q   <= cr_d;
    end
  end

endmodule

// ===== src/sst_queue.sv =====
// sst_queue: small queue of token runs between front and back
// depends on sst_pkg
module sst_queue import sst_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output run_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== src/sst_back.sv =====
// sst_back: takes token runs from the queue and sends one token per cycle while not stalled
// depends on sst_pkg; output register toward the consumer
module sst_back import sst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  run_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       run_last_o
);

  logic  out_valid_q;
  kind_e kind_q;
  logic [7:0] byte_q;
  logic  last_q;
  logic  half_q;
  logic  load;
  tok_t  cur;
  logic  cur_last;

  assign load = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    cur      = half_q ? head_i.t1 : head_i.t0;
    cur_last = half_q || !head_i.two;
    pop_o    = load && cur_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      half_q      <= !cur_last;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= cur.kind;
      byte_q <= cur.data;
      last_q <= cur_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign token_kind_o = kind_q;
  assign token_byte_o = byte_q;
  assign run_last_o   = last_q;

endmodule

// ===== src/sse_stream_tokenizer.sv =====
// sse_stream_tokenizer: top level of the server-sent-events byte tokenizer
// depends on sst_pkg, sst_front, sst_queue, sst_back
//
// Takes one stream byte per cycle and gives tagged tokens (data bytes, event and
// id value starts and bytes, dispatch marks), one token per cycle while not
// stalled. A byte is classified and the line state updated in the cycle it is
// accepted; the one or two tokens it causes enter a queue of QueueDepth entries
// as one item (a byte causing none pushes nothing), and the output stage drains
// them one token per cycle while not stalled, so a token passes the queue and
// then the output register. A byte causing two tokens gives them in turn; input
// stalls only when the queue is full; run_last_o marks each byte's final token.
module sse_stream_tokenizer import sst_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       run_last_o
);

  logic q_push, q_full, q_pop, q_empty;
  run_t q_in, q_head;

  sst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .run_o      (q_in)
  );

  sst_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  sst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .token_byte_o (token_byte_o),
    .run_last_o   (run_last_o)
  );

  // second token of a run follows right after the first
  a_run_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !run_last_o) |=> (out_valid_o && run_last_o))
    else $error("second token of a run missing");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_dispatch_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == KIND_DISPATCH)) |-> (run_last_o && (token_byte_o == 8'd0)))
    else $error("dispatch mark malformed");

endmodule

// ===== verif/sse_stream_tokenizer_test.sv =====
`timescale 1ns / 100ps
// sse_stream_tokenizer_test: self-checking testbench for the sse stream tokenizer
// directed byte table then random event-stream lines, checked against a line-state predictor
// depends on sst_pkg and sse_stream_tokenizer
module sse_stream_tokenizer_test;
  import sst_pkg::*;

  localparam int DIR_ROWS     = 39;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 120;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       is_last;
  } tok_exp_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    int         n;
    tok_exp_t   t0;
    tok_exp_t   t1;
  } dir_row_t;

  localparam tok_exp_t NO_TOK = '{kind: KIND_DATA, data: 8'd0, is_last: 1'b0};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] byte_in_i   = 8'd0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] token_kind_o;
  logic [7:0] token_byte_o;
  logic       run_last_o;

  // line state of the predictor
  phase_e     cur_phase = PH_START;
  field_e     cur_field = FIELD_NONE;
  logic [2:0] cur_pos   = 3'd0;
  logic       cr_held   = 1'b0;
  logic       data_seen = 1'b0;

  tok_exp_t   run_toks[$];
  tok_exp_t   pending_tokens[$];
  int         mismatches    = 0;
  int         bytes_sent    = 0;
  bit         in_idle_on    = 1'b1;
  bit         out_idle_on   = 1'b1;
  bit         long_hold_req = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{LF_BYTE, 1'b1, 0, NO_TOK, NO_TOK},
    '{"d", 1'b0, 0, NO_TOK, NO_TOK},
    '{"a", 1'b0, 0, NO_TOK, NO_TOK},
    '{"t", 1'b0, 0, NO_TOK, NO_TOK},
    '{"a", 1'b0, 0, NO_TOK, NO_TOK},
    '{":", 1'b0, 0, NO_TOK, NO_TOK},
    '{SPACE_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{8'hFF, 1'b1, 1, '{kind: KIND_DATA, data: 8'hFF, is_last: 1'b1}, NO_TOK},
    '{CR_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{CR_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{8'h00, 1'b1, 2, '{kind: KIND_DATA, data: CR_BYTE, is_last: 1'b0},
      '{kind: KIND_DATA, data: 8'h00, is_last: 1'b1}},
    '{LF_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{"d", 1'b0, 0, NO_TOK, NO_TOK},
    '{"a", 1'b0, 0, NO_TOK, NO_TOK},
    '{"t", 1'b0, 0, NO_TOK, NO_TOK},
    '{"a", 1'b0, 0, NO_TOK, NO_TOK},
    '{":", 1'b0, 0, NO_TOK, NO_TOK},
    '{CR_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{"i", 1'b0, 0, NO_TOK, NO_TOK},
    '{LF_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{LF_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{"i", 1'b0, 0, NO_TOK, NO_TOK},
    '{"d", 1'b0, 0, NO_TOK, NO_TOK},
    '{":", 1'b0, 0, NO_TOK, NO_TOK},
    '{"d", 1'b0, 0, NO_TOK, NO_TOK},
    '{CR_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{LF_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{"e", 1'b0, 0, NO_TOK, NO_TOK},
    '{"v", 1'b0, 0, NO_TOK, NO_TOK},
    '{"e", 1'b0, 0, NO_TOK, NO_TOK},
    '{"n", 1'b0, 0, NO_TOK, NO_TOK},
    '{"t", 1'b0, 0, NO_TOK, NO_TOK},
    '{":", 1'b0, 0, NO_TOK, NO_TOK},
    '{"x", 1'b0, 0, NO_TOK, NO_TOK},
    '{LF_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{"d", 1'b0, 0, NO_TOK, NO_TOK},
    '{CR_BYTE, 1'b0, 0, NO_TOK, NO_TOK},
    '{":", 1'b0, 0, NO_TOK, NO_TOK},
    '{LF_BYTE, 1'b0, 0, NO_TOK, NO_TOK}
  };

  sse_stream_tokenizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .token_byte_o (token_byte_o),
    .run_last_o   (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic string field_word(field_e f);
    case (f)
      FIELD_DATA:  return "data";
      FIELD_EVENT: return "event";
      FIELD_ID:    return "id";
      default:     return "";
    endcase
  endfunction

  function automatic kind_e byte_kind(field_e f);
    case (f)
      FIELD_EVENT: return KIND_EVENT_BYTE;
      FIELD_ID:    return KIND_ID_BYTE;
      default:     return KIND_DATA;
    endcase
  endfunction

  function automatic void add_token(kind_e k, logic [7:0] d);
    tok_exp_t t;
    t = '{kind: k, data: d, is_last: 1'b0};
    run_toks.insert(run_toks.size(), t);
  endfunction

  function automatic void feed_line_byte(logic [7:0] c);
    string name;
    name = field_word(cur_field);
    case (cur_phase)
      PH_START: begin
        cur_pos = 3'd0;
        case (c)
          "d":     cur_field = FIELD_DATA;
          "e":     cur_field = FIELD_EVENT;
          "i":     cur_field = FIELD_ID;
          default: cur_field = FIELD_NONE;
        endcase
        if (cur_field != FIELD_NONE) begin
          cur_phase = PH_NAME;
          cur_pos   = 3'd1;
        end else begin
          cur_phase = PH_SKIP;
        end
      end
      PH_NAME: begin
        if ((cur_pos < name.len()) && (c == name[cur_pos])) begin
          cur_pos = cur_pos + 3'd1;
        end else if ((c == COLON_BYTE) && (cur_pos == name.len()) &&
                     (cur_field != FIELD_NONE)) begin
          case (cur_field)
            FIELD_DATA: begin
              if (data_seen) add_token(KIND_DATA, LF_BYTE);
              data_seen = 1'b1;
            end
            FIELD_EVENT: add_token(KIND_EVENT_START, 8'd0);
            default:     add_token(KIND_ID_START, 8'd0);
          endcase
          cur_phase = PH_AFTER_COLON;
        end else begin
          cur_phase = PH_SKIP;
        end
      end
      PH_AFTER_COLON: begin
        cur_phase = PH_VALUE;
        if (c != SPACE_BYTE) add_token(byte_kind(cur_field), c);
      end
      PH_VALUE: begin
        add_token(byte_kind(cur_field), c);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void close_line();
    if ((cur_phase == PH_START) && data_seen) begin
      add_token(KIND_DISPATCH, 8'd0);
      data_seen = 1'b0;
    end
    cur_phase = PH_START;
    cur_field = FIELD_NONE;
    cur_pos   = 3'd0;
  endfunction

  // tokens caused by one accepted item, left in run_toks
  function automatic void predict_tokens(logic [7:0] b);
    tok_exp_t t;
    run_toks.delete();
    if (b == LF_BYTE) begin
      cr_held = 1'b0;
      close_line();
    end else begin
      if (cr_held) begin
        cr_held = 1'b0;
        feed_line_byte(CR_BYTE);
      end
      if (b == CR_BYTE) cr_held = 1'b1;
      else feed_line_byte(b);
    end
    if (run_toks.size() > 0) begin
      t = run_toks[run_toks.size() - 1];
      t.is_last = 1'b1;
      run_toks[run_toks.size() - 1] = t;
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] v;
    if ($urandom_range(0, 9) == 0) return CR_BYTE;
    do v = 8'($urandom_range(0, 255)); while (v == LF_BYTE);
    return v;
  endfunction

  // returns at the edge where the item is taken
  task automatic offer_byte(input logic [7:0] b);
    int g;
    g = in_idle_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer_byte(b);
    predict_tokens(b);
    foreach (run_toks[i]) pending_tokens.insert(pending_tokens.size(), run_toks[i]);
  endtask

  task automatic send_random_line();
    int         r;
    int         n;
    int         cut;
    string      w;
    logic [7:0] q[$];
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       w = "data";
      1:       w = "event";
      default: w = "id";
    endcase
    if (r < 65) begin
      if (r < 40) w = "data";
      else if (r < 55) w = "event";
      else w = "id";
      for (int i = 0; i < w.len(); i++) q.insert(q.size(), w[i]);
      q.insert(q.size(), COLON_BYTE);
      if ($urandom_range(0, 1)) q.insert(q.size(), SPACE_BYTE);
      n = $urandom_range(0, 8);
      repeat (n) q.insert(q.size(), value_byte());
    end else if (r < 78) begin
      // empty line
    end else if (r < 84) begin
      q.insert(q.size(), COLON_BYTE);
      n = $urandom_range(0, 6);
      repeat (n) q.insert(q.size(), value_byte());
    end else if (r < 92) begin
      // field name cut short or broken by a stray byte
      cut = $urandom_range(0, w.len());
      for (int i = 0; i < cut; i++) q.insert(q.size(), w[i]);
      case ($urandom_range(0, 2))
        0:       q.insert(q.size(), CR_BYTE);
        1:       q.insert(q.size(), COLON_BYTE);
        default: q.insert(q.size(), value_byte());
      endcase
      q.insert(q.size(), COLON_BYTE);
      n = $urandom_range(0, 4);
      repeat (n) q.insert(q.size(), value_byte());
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) q.insert(q.size(), CR_BYTE);
    q.insert(q.size(), LF_BYTE);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_tokens.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer_byte(dir_rows[i].b);
      predict_tokens(dir_rows[i].b);
      if (dir_rows[i].typed) begin
        run_toks.delete();
        if (dir_rows[i].n > 0) run_toks.insert(run_toks.size(), dir_rows[i].t0);
        if (dir_rows[i].n > 1) run_toks.insert(run_toks.size(), dir_rows[i].t1);
      end
      foreach (run_toks[j]) pending_tokens.insert(pending_tokens.size(), run_toks[j]);
    end

    while (bytes_sent < 500) send_random_line();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    while (bytes_sent < 700) send_random_line();
    // receiver holds off while items keep coming
    long_hold_req = 1'b1;
    while (bytes_sent < 780) send_random_line();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    drain_tokens();
    while (bytes_sent < 1340) send_random_line();
    drain_tokens();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i   <= 1'b0;
        long_hold_req  = 1'b0;
      end else begin
        n = out_idle_on ? gap_len() : 0;
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : token_check
    tok_exp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token kind %0d byte %h last %b", $time,
                 token_kind_o, token_byte_o, run_last_o);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (token_kind_o != want.kind) begin
          $display("%0t: token kind expected %0d got %0d", $time, want.kind, token_kind_o);
          mismatches++;
        end
        if (token_byte_o != want.data) begin
          $display("%0t: token byte expected %h got %h", $time, want.data, token_byte_o);
          mismatches++;
        end
        if (run_last_o != want.is_last) begin
          $display("%0t: run_last expected %b got %b", $time, want.is_last, run_last_o);
          mismatches++;
        end
      end
    end
  end

endmodule
